### src/dda_line_rasterizer_core_defines.svh
// Assertion macros shared by the rasterizer RTL.
// Included by modules that carry concurrent checks; no other dependencies.
`ifndef DDA_LINE_RASTERIZER_CORE_DEFINES_SVH
`define DDA_LINE_RASTERIZER_CORE_DEFINES_SVH

// same-cycle implication, disabled during reset
`define DLR_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("dlr assertion failed");

// next-cycle implication, disabled during reset
`define DLR_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("dlr assertion failed");

`endif

### src/dlr_pkg.sv
// Shared types and constants for the DDA line rasterizer.
// No dependencies; imported by every rasterizer module.
`timescale 1ns / 1ps

package dlr_pkg;

    localparam int COORD_FRAC_BITS = 4;
    localparam int COORD_INT_BITS  = 12;
    localparam int INC_FRAC_BITS   = 16;

    localparam int COORD_W    = COORD_INT_BITS + COORD_FRAC_BITS;
    localparam int STEP_W     = COORD_W - COORD_FRAC_BITS;
    localparam int INC_SHIFT  = INC_FRAC_BITS - COORD_FRAC_BITS;
    localparam int DIVIDEND_W = COORD_W + INC_SHIFT;
    localparam int DIV_CNT_W  = $clog2(DIVIDEND_W);
    localparam int INC_W      = 24;
    localparam int POS_W      = 32;
    localparam int RX_W       = POS_W - INC_FRAC_BITS;
    localparam int PIX_W      = 13;
    localparam int DIM_W      = 13;

    localparam logic [INC_W-2:0] INC_MAG_MAX = '1;

    localparam logic ACT_LOAD = 1'b0;
    localparam logic ACT_STEP = 1'b1;

    typedef enum logic {
        KIND_LOAD,
        KIND_STEP
    } kind_t;

    typedef struct packed {
        kind_t               kind;
        logic                done;
        logic [STEP_W-1:0]   step;
        logic [COORD_W-1:0]  mag_x;
        logic [COORD_W-1:0]  mag_y;
        logic                neg_x;
        logic                neg_y;
        logic [COORD_W-1:0]  start_x;
        logic [COORD_W-1:0]  start_y;
    } cmd_t;

endpackage

### src/dda_line_rasterizer_core.sv
// DDA line rasterizer top level: config registers, front end, command queue, back end.
// Depends on dlr_pkg, dlr_front, dlr_queue, dlr_back (and dlr_div below it).
//
// Input channel (in_valid/in_stall): action 0 loads a line from start_x/y to end_x/y
// (signed Q12.4), action 1 advances one step. Output channel (out_valid/out_stall):
// one pixel word per cycle while not stalled, four per emitting word, in brush order
// (x,y), (x-1,y), (x,y-1), (x-1,y-1); block_last marks the fourth, line_done
// the fourth of the last. A step word with no line in progress produces nothing.
// A step word passes through a queue entry, the back end position register and the
// pixel output register; a load with nonzero length first runs the increment divider
// (one quotient bit per cycle over 28 bits). The back end pops the next step word only
// as the single pixel output register takes the fourth pixel of the previous one.
// in_stall rises when the command queue (QUEUE_DEPTH words) is full. When out_stall
// is high the output register holds its word, the back end waits and the queue fills.
// Reset clears the queue, leaves no line loaded and sets image size to 640 x 480.
// Config: APB writes at 0x0 (image_width) and 0x4 (image_height), to be written only
// while the block is idle (the block does not enforce it); reads return their values.
`timescale 1ns / 1ps

module dda_line_rasterizer_core
    import dlr_pkg::*;
#(
    parameter int QUEUE_DEPTH = 2
)
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_stall,
    input  logic                action,
    input  logic signed [15:0]  start_x,
    input  logic signed [15:0]  start_y,
    input  logic signed [15:0]  end_x,
    input  logic signed [15:0]  end_y,
    output logic                out_valid,
    input  logic                out_stall,
    output logic signed [12:0]  pixel_x,
    output logic signed [12:0]  pixel_y,
    output logic                colour_sel,
    output logic                inside_res,
    output logic                line_done,
    output logic                block_last,
    input  logic                psel,
    input  logic                penable,
    input  logic                pwrite,
    input  logic [2:0]          paddr,
    input  logic [31:0]         pwdata,
    output logic [31:0]         prdata,
    output logic                pready
);

    localparam logic             REG_IMAGE_WIDTH  = 1'b0;
    localparam logic             REG_IMAGE_HEIGHT = 1'b1;
    localparam logic [DIM_W-1:0] WIDTH_RESET      = DIM_W'(640);
    localparam logic [DIM_W-1:0] HEIGHT_RESET     = DIM_W'(480);

    logic [DIM_W-1:0] image_width_reg;
    logic [DIM_W-1:0] image_height_reg;
    logic             cfg_write;
    logic             q_full;
    logic             q_push;
    cmd_t             q_push_cmd;
    logic             q_pop;
    logic             q_valid;
    cmd_t             q_cmd;
    logic [PIX_W-1:0] pix_x;
    logic [PIX_W-1:0] pix_y;

    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite;
    assign prdata    = (paddr[2] == REG_IMAGE_HEIGHT) ? {{(32-DIM_W){1'b0}}, image_height_reg}
                                                      : {{(32-DIM_W){1'b0}}, image_width_reg};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            image_width_reg  <= WIDTH_RESET;
            image_height_reg <= HEIGHT_RESET;
        end
        else if (cfg_write)
        begin
            if (paddr[2] == REG_IMAGE_WIDTH)
                image_width_reg <= pwdata[DIM_W-1:0];
            else
                image_height_reg <= pwdata[DIM_W-1:0];
        end
    end

    dlr_front u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_stall (in_stall),
        .action   (action),
        .start_x  (start_x),
        .start_y  (start_y),
        .end_x    (end_x),
        .end_y    (end_y),
        .q_full   (q_full),
        .push     (q_push),
        .push_cmd (q_push_cmd)
    );

    dlr_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (q_push),
        .push_cmd  (q_push_cmd),
        .full      (q_full),
        .pop       (q_pop),
        .pop_valid (q_valid),
        .pop_cmd   (q_cmd)
    );

    dlr_back u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .q_valid      (q_valid),
        .q_cmd        (q_cmd),
        .q_pop        (q_pop),
        .image_width  (image_width_reg),
        .image_height (image_height_reg),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .pixel_x      (pix_x),
        .pixel_y      (pix_y),
        .colour_sel   (colour_sel),
        .inside_res   (inside_res),
        .line_done    (line_done),
        .block_last   (block_last)
    );

    assign pixel_x = signed'(pix_x);
    assign pixel_y = signed'(pix_y);

endmodule

### src/dlr_front.sv
// Front end: accepts input words, works out line length and deltas, queues commands.
// Depends on dlr_pkg.
`timescale 1ns / 1ps

module dlr_front
    import dlr_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_stall,
    input  logic                action,
    input  logic [COORD_W-1:0]  start_x,
    input  logic [COORD_W-1:0]  start_y,
    input  logic [COORD_W-1:0]  end_x,
    input  logic [COORD_W-1:0]  end_y,
    input  logic                q_full,
    output logic                push,
    output cmd_t                push_cmd
);

    localparam int DW = COORD_W + 1;

    logic [STEP_W-1:0]  steps_left_reg;
    logic [STEP_W-1:0]  steps_left_next;
    logic               accept;
    logic [DW-1:0]      dx;
    logic [DW-1:0]      dy;
    logic [DW-1:0]      abs_x;
    logic [DW-1:0]      abs_y;
    logic [COORD_W-1:0] mag_x;
    logic [COORD_W-1:0] mag_y;
    logic [COORD_W-1:0] mag_max;
    logic [STEP_W-1:0]  step_v;

    assign accept   = in_valid && !q_full;
    assign in_stall = q_full;

    assign dx      = {end_x[COORD_W-1], end_x} - {start_x[COORD_W-1], start_x};
    assign dy      = {end_y[COORD_W-1], end_y} - {start_y[COORD_W-1], start_y};
    assign abs_x   = dx[DW-1] ? (DW'(0) - dx) : dx;
    assign abs_y   = dy[DW-1] ? (DW'(0) - dy) : dy;
    assign mag_x   = abs_x[COORD_W-1:0];
    assign mag_y   = abs_y[COORD_W-1:0];
    assign mag_max = (mag_x > mag_y) ? mag_x : mag_y;
    assign step_v  = mag_max[COORD_W-1:COORD_FRAC_BITS];

    // a step word with no line in progress is swallowed here
    assign push = accept && ((action == ACT_LOAD) || (steps_left_reg != '0));

    always_comb
    begin
        push_cmd.kind    = (action == ACT_LOAD) ? KIND_LOAD : KIND_STEP;
        push_cmd.done    = (action == ACT_LOAD) ? (step_v == '0)
                                                : (steps_left_reg == STEP_W'(1));
        push_cmd.step    = step_v;
        push_cmd.mag_x   = mag_x;
        push_cmd.mag_y   = mag_y;
        push_cmd.neg_x   = dx[DW-1];
        push_cmd.neg_y   = dy[DW-1];
        push_cmd.start_x = start_x;
        push_cmd.start_y = start_y;
    end

    always_comb
    begin
        steps_left_next = steps_left_reg;
        if (accept)
        begin
            if (action == ACT_LOAD)
                steps_left_next = step_v;
            else if (steps_left_reg != '0)
                steps_left_next = steps_left_reg - STEP_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            steps_left_reg <= '0;
        else
            steps_left_reg <= steps_left_next;
    end

endmodule

### src/dlr_queue.sv
// Small command FIFO between the front and back ends.
// Depends on dlr_pkg for the command type.
`timescale 1ns / 1ps

module dlr_queue
    import dlr_pkg::*;
#(
    parameter int DEPTH = 2
)
(
    input  logic clk,
    input  logic rst_n,
    input  logic push,
    input  cmd_t push_cmd,
    output logic full,
    input  logic pop,
    output logic pop_valid,
    output cmd_t pop_cmd
);

    localparam int PW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);
    localparam logic [PW-1:0] LAST_PTR = PW'(DEPTH - 1);
    localparam logic [CW-1:0] FULL_CNT = CW'(DEPTH);

    cmd_t          entry_reg [DEPTH];
    logic [PW-1:0] wr_ptr_reg;
    logic [PW-1:0] rd_ptr_reg;
    logic [CW-1:0] count_reg;
    logic          do_push;
    logic          do_pop;

    assign full      = (count_reg == FULL_CNT);
    assign pop_valid = (count_reg != '0);
    assign pop_cmd   = entry_reg[rd_ptr_reg];
    assign do_push   = push && !full;
    assign do_pop    = pop && pop_valid;

    always_ff @(posedge clk)
    begin
        if (do_push)
            entry_reg[wr_ptr_reg] <= push_cmd;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (do_push)
                wr_ptr_reg <= (wr_ptr_reg == LAST_PTR) ? '0 : wr_ptr_reg + PW'(1);
            if (do_pop)
                rd_ptr_reg <= (rd_ptr_reg == LAST_PTR) ? '0 : rd_ptr_reg + PW'(1);
            if (do_push && !do_pop)
                count_reg <= count_reg + CW'(1);
            else if (do_pop && !do_push)
                count_reg <= count_reg - CW'(1);
        end
    end

endmodule

### src/dlr_div.sv
// Radix-2 restoring divider for one increment: (mag << INC_SHIFT) / step, saturated.
// Depends on dlr_pkg. One quotient bit per cycle, DIVIDEND_W bits per divide.
`timescale 1ns / 1ps

module dlr_div
    import dlr_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    input  logic [COORD_W-1:0] mag,
    input  logic [STEP_W-1:0]  divisor,
    output logic               done,
    output logic [INC_W-2:0]   quot
);

    localparam logic [DIV_CNT_W-1:0] LAST_CNT = DIV_CNT_W'(DIVIDEND_W - 1);

    logic                  busy_reg;
    logic                  done_reg;
    logic [DIV_CNT_W-1:0]  cnt_reg;
    logic [DIVIDEND_W-1:0] num_reg;
    logic [DIVIDEND_W-1:0] q_reg;
    logic [STEP_W-1:0]     rem_reg;
    logic [STEP_W-1:0]     div_reg;
    logic [STEP_W:0]       rem_shift;
    logic [STEP_W:0]       rem_diff;
    logic                  ge;

    assign rem_shift = {rem_reg, num_reg[DIVIDEND_W-1]};
    assign rem_diff  = rem_shift - {1'b0, div_reg};
    assign ge        = rem_shift >= {1'b0, div_reg};

    assign done = done_reg;
    // quotient bits above the increment range saturate it
    assign quot = (q_reg[DIVIDEND_W-1:INC_W-1] != '0) ? INC_MAG_MAX : q_reg[INC_W-2:0];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg + DIV_CNT_W'(1);
                if (cnt_reg == LAST_CNT)
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            num_reg <= {mag, {INC_SHIFT{1'b0}}};
            div_reg <= divisor;
            rem_reg <= '0;
            q_reg   <= '0;
        end
        else if (busy_reg)
        begin
            num_reg <= {num_reg[DIVIDEND_W-2:0], 1'b0};
            rem_reg <= ge ? rem_diff[STEP_W-1:0] : rem_shift[STEP_W-1:0];
            q_reg   <= {q_reg[DIVIDEND_W-2:0], ge};
        end
    end

endmodule

### src/dlr_back.sv
// Back end: holds position and increments, runs the divides, emits 2x2 brush words.
// Depends on dlr_pkg, dlr_div and the assertion macro header.
`timescale 1ns / 1ps
`include "dda_line_rasterizer_core_defines.svh"

module dlr_back
    import dlr_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               q_valid,
    input  cmd_t               q_cmd,
    output logic               q_pop,
    input  logic [DIM_W-1:0]   image_width,
    input  logic [DIM_W-1:0]   image_height,
    output logic               out_valid,
    input  logic               out_stall,
    output logic [PIX_W-1:0]   pixel_x,
    output logic [PIX_W-1:0]   pixel_y,
    output logic               colour_sel,
    output logic               inside_res,
    output logic               line_done,
    output logic               block_last
);

    typedef enum logic [1:0] {
        S_IDLE,
        S_DIV,
        S_EMIT
    } state_t;

    localparam logic [POS_W-1:0] ROUND_HALF = POS_W'(1) << (INC_FRAC_BITS - 1);
    localparam int               POS_PAD    = POS_W - COORD_W - INC_SHIFT;

    state_t                 state_reg;
    logic [POS_W-1:0]       pos_x_reg;
    logic [POS_W-1:0]       pos_y_reg;
    logic [INC_W-1:0]       inc_x_reg;
    logic [INC_W-1:0]       inc_y_reg;
    logic                   neg_x_reg;
    logic                   neg_y_reg;
    logic                   colour_reg;
    logic                   done_reg;
    logic [1:0]             k_reg;
    logic                   out_valid_reg;
    logic [PIX_W-1:0]       pixel_x_reg;
    logic [PIX_W-1:0]       pixel_y_reg;
    logic                   colour_sel_reg;
    logic                   inside_res_reg;
    logic                   line_done_reg;
    logic                   block_last_reg;

    logic                   out_load;
    logic                   last_pix;
    logic                   div_start;
    logic                   div_x_done;
    logic                   div_y_done;
    logic [INC_W-2:0]       quot_x;
    logic [INC_W-2:0]       quot_y;
    logic [POS_W-1:0]       round_x;
    logic [POS_W-1:0]       round_y;
    logic [RX_W:0]          px;
    logic [RX_W:0]          py;
    logic                   inside_v;

    assign out_load  = (state_reg == S_EMIT) && (!out_valid_reg || !out_stall);
    assign last_pix  = (k_reg == 2'd3);
    assign q_pop     = q_valid && ((state_reg == S_IDLE) || (out_load && last_pix));
    assign div_start = q_pop && (q_cmd.kind == KIND_LOAD) && (q_cmd.step != '0);

    dlr_div u_div_x (
        .clk     (clk),
        .rst_n   (rst_n),
        .start   (div_start),
        .mag     (q_cmd.mag_x),
        .divisor (q_cmd.step),
        .done    (div_x_done),
        .quot    (quot_x)
    );

    dlr_div u_div_y (
        .clk     (clk),
        .rst_n   (rst_n),
        .start   (div_start),
        .mag     (q_cmd.mag_y),
        .divisor (q_cmd.step),
        .done    (div_y_done),
        .quot    (quot_y)
    );

    // floor(pos + 0.5) is the upper half after adding one half
    assign round_x = pos_x_reg + ROUND_HALF;
    assign round_y = pos_y_reg + ROUND_HALF;
    // brush order: (x,y), (x-1,y), (x,y-1), (x-1,y-1)
    assign px = {round_x[POS_W-1], round_x[POS_W-1:INC_FRAC_BITS]} - {{RX_W{1'b0}}, k_reg[0]};
    assign py = {round_y[POS_W-1], round_y[POS_W-1:INC_FRAC_BITS]} - {{RX_W{1'b0}}, k_reg[1]};
    assign inside_v = !px[RX_W] && !py[RX_W]
                   && (px[RX_W-1:0] < {{(RX_W-DIM_W){1'b0}}, image_width})
                   && (py[RX_W-1:0] < {{(RX_W-DIM_W){1'b0}}, image_height});

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            out_valid_reg <= 1'b0;
            k_reg         <= '0;
            pos_x_reg     <= '0;
            pos_y_reg     <= '0;
            inc_x_reg     <= '0;
            inc_y_reg     <= '0;
        end
        else
        begin
            if (out_load)
            begin
                out_valid_reg  <= 1'b1;
                pixel_x_reg    <= px[PIX_W-1:0];
                pixel_y_reg    <= py[PIX_W-1:0];
                colour_sel_reg <= colour_reg;
                inside_res_reg <= inside_v;
                line_done_reg  <= done_reg && last_pix;
                block_last_reg <= last_pix;
            end
            else if (!out_stall)
                out_valid_reg <= 1'b0;

            case (state_reg)
                S_IDLE:
                begin
                end
                S_DIV:
                begin
                    if (div_x_done)
                    begin
                        inc_x_reg <= neg_x_reg ? (INC_W'(0) - {1'b0, quot_x}) : {1'b0, quot_x};
                        inc_y_reg <= neg_y_reg ? (INC_W'(0) - {1'b0, quot_y}) : {1'b0, quot_y};
                        state_reg <= S_EMIT;
                        k_reg     <= '0;
                    end
                end
                S_EMIT:
                begin
                    if (out_load && !q_pop)
                    begin
                        k_reg <= k_reg + 2'd1;
                        if (last_pix)
                            state_reg <= S_IDLE;
                    end
                end
                default:
                    state_reg <= S_IDLE;
            endcase

            // next word from the queue starts here
            if (q_pop)
            begin
                k_reg      <= '0;
                done_reg   <= q_cmd.done;
                colour_reg <= (q_cmd.kind == KIND_STEP);
                if (q_cmd.kind == KIND_LOAD)
                begin
                    pos_x_reg <= {{POS_PAD{q_cmd.start_x[COORD_W-1]}}, q_cmd.start_x,
                                  {INC_SHIFT{1'b0}}};
                    pos_y_reg <= {{POS_PAD{q_cmd.start_y[COORD_W-1]}}, q_cmd.start_y,
                                  {INC_SHIFT{1'b0}}};
                    neg_x_reg <= q_cmd.neg_x;
                    neg_y_reg <= q_cmd.neg_y;
                    if (q_cmd.step == '0)
                    begin
                        inc_x_reg <= '0;
                        inc_y_reg <= '0;
                        state_reg <= S_EMIT;
                    end
                    else
                        state_reg <= S_DIV;
                end
                else
                begin
                    pos_x_reg <= pos_x_reg + {{(POS_W-INC_W){inc_x_reg[INC_W-1]}}, inc_x_reg};
                    pos_y_reg <= pos_y_reg + {{(POS_W-INC_W){inc_y_reg[INC_W-1]}}, inc_y_reg};
                    state_reg <= S_EMIT;
                end
            end
        end
    end

    assign out_valid  = out_valid_reg;
    assign pixel_x    = pixel_x_reg;
    assign pixel_y    = pixel_y_reg;
    assign colour_sel = colour_sel_reg;
    assign inside_res = inside_res_reg;
    assign line_done  = line_done_reg;
    assign block_last = block_last_reg;

    `DLR_ASSERT_NOW(a_div_lanes_together, clk, rst_n, 1'b1, div_x_done == div_y_done)
    `DLR_ASSERT_NOW(a_no_pop_in_div, clk, rst_n, state_reg == S_DIV, !q_pop)
    `DLR_ASSERT_NEXT(a_div_start_enters_div, clk, rst_n, div_start, state_reg == S_DIV)
    `DLR_ASSERT_NOW(a_done_is_block_end, clk, rst_n, out_valid_reg && line_done_reg,
                    block_last_reg)

endmodule

### tb/sv/dda_line_rasterizer_core_test.sv
// Self-checking testbench for dda_line_rasterizer_core: directed table, then random lines.
// Holds its own line stepper to predict pixel words; depends on dlr_pkg and the core RTL.
`timescale 1ns / 1ps

module dda_line_rasterizer_core_test;
    import dlr_pkg::*;

    localparam logic [2:0] REG_IMAGE_WIDTH  = 3'h0;
    localparam logic [2:0] REG_IMAGE_HEIGHT = 3'h4;
    localparam int INC_LIMIT      = 'h7F_FFFF;
    localparam int SETTLE_CYCLES  = 48;
    localparam int HOLD_CYCLES    = 300;
    localparam int WATCHDOG_LIMIT = 5000;
    localparam int PHASE_WORDS    = 55;
    localparam int NUM_PHASES     = 7;

    typedef struct packed {
        logic [12:0] x;
        logic [12:0] y;
        logic        colour;
        logic        in_image;
        logic        done;
        logic        last;
    } pixel_t;

    typedef struct {
        logic               act;
        logic signed [15:0] sx;
        logic signed [15:0] sy;
        logic signed [15:0] ex;
        logic signed [15:0] ey;
        bit                 typed;
        int                 nres;
        int                 bx;
        int                 by;
        logic               colour;
        logic [3:0]         mask;
        bit                 done;
    } stim_row_t;

    logic               clk      = 1'b0;
    logic               rst_n    = 1'b0;
    logic               in_valid = 1'b0;
    logic               in_stall;
    logic               action   = 1'b0;
    logic signed [15:0] start_x  = '0;
    logic signed [15:0] start_y  = '0;
    logic signed [15:0] end_x    = '0;
    logic signed [15:0] end_y    = '0;
    logic               out_valid;
    logic               out_stall = 1'b0;
    logic signed [12:0] pixel_x;
    logic signed [12:0] pixel_y;
    logic               colour_sel;
    logic               inside_res;
    logic               line_done;
    logic               block_last;
    logic               psel     = 1'b0;
    logic               penable  = 1'b0;
    logic               pwrite   = 1'b0;
    logic [2:0]         paddr    = '0;
    logic [31:0]        pwdata   = '0;
    logic [31:0]        prdata;
    logic               pready;

    // line stepper state mirrored by the testbench
    logic [31:0] line_pos_x  = '0;
    logic [31:0] line_pos_y  = '0;
    int          line_inc_x  = 0;
    int          line_inc_y  = 0;
    logic [12:0] line_steps  = '0;
    bit          line_active = 1'b0;
    logic [12:0] cfg_width   = 13'd640;
    logic [12:0] cfg_height  = 13'd480;

    pixel_t    pending_pixels[$];
    stim_row_t directed_rows[$];
    int        mismatch_count = 0;
    int        quiet_cycles   = 0;
    bit        no_gaps        = 1'b0;
    logic      rx_quiet       = 1'b0;
    int        hold_req       = 0;
    int        hold_seen      = 0;
    int        hold_left      = 0;
    int        run_left       = 0;

    dda_line_rasterizer_core dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_stall   (in_stall),
        .action     (action),
        .start_x    (start_x),
        .start_y    (start_y),
        .end_x      (end_x),
        .end_y      (end_y),
        .out_valid  (out_valid),
        .out_stall  (out_stall),
        .pixel_x    (pixel_x),
        .pixel_y    (pixel_y),
        .colour_sel (colour_sel),
        .inside_res (inside_res),
        .line_done  (line_done),
        .block_last (block_last),
        .psel       (psel),
        .penable    (penable),
        .pwrite     (pwrite),
        .paddr      (paddr),
        .pwdata     (pwdata),
        .prdata     (prdata),
        .pready     (pready)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    function automatic logic [31:0] round_to_pixel(input logic [31:0] v);
        logic [31:0] t;
        t = v + (32'd1 << (INC_FRAC_BITS - 1));
        return $unsigned($signed(t) >>> INC_FRAC_BITS);
    endfunction

    function automatic int line_increment(input int delta, input int span);
        longint mag;
        longint q;
        if (span == 0)
            return 0;
        mag = (delta < 0) ? -longint'(delta) : longint'(delta);
        q = (mag << INC_SHIFT) / span;
        if (q > INC_LIMIT)
            q = INC_LIMIT;
        return (delta < 0) ? -int'(q) : int'(q);
    endfunction

    // apply one accepted word to the mirrored stepper, return the brush pixels it draws
    task automatic advance_line(input stim_row_t r, output pixel_t blk[$]);
        int          sx, sy, dx, dy, ax, ay, span;
        logic [31:0] rx, ry, px, py;
        logic        colour;
        bit          last_block;
        bit          emit;
        pixel_t      p;
        blk = {};
        emit = 1'b0;
        colour = 1'b0;
        last_block = 1'b0;
        if (r.act == ACT_LOAD)
        begin
            sx = r.sx;
            sy = r.sy;
            dx = int'(r.ex) - sx;
            dy = int'(r.ey) - sy;
            ax = (dx < 0) ? -dx : dx;
            ay = (dy < 0) ? -dy : dy;
            span = ((ax > ay) ? ax : ay) >>> COORD_FRAC_BITS;
            line_inc_x = line_increment(dx, span);
            line_inc_y = line_increment(dy, span);
            line_pos_x = 32'(sx) << INC_SHIFT;
            line_pos_y = 32'(sy) << INC_SHIFT;
            line_steps = 13'(span);
            line_active = (span != 0);
            last_block = (span == 0);
            emit = 1'b1;
        end
        else if (line_active && line_steps != 0)
        begin
            line_pos_x = line_pos_x + 32'(line_inc_x);
            line_pos_y = line_pos_y + 32'(line_inc_y);
            line_steps = line_steps - 13'd1;
            if (line_steps == 0)
                line_active = 1'b0;
            colour = 1'b1;
            last_block = (line_steps == 0);
            emit = 1'b1;
        end
        if (emit)
        begin
            rx = round_to_pixel(line_pos_x);
            ry = round_to_pixel(line_pos_y);
            for (int k = 0; k < 4; k++)
            begin
                px = rx - 32'(k & 1);
                py = ry - 32'(k >> 1);
                p.x = px[12:0];
                p.y = py[12:0];
                p.colour = colour;
                // inside test uses the full coordinate, not the 13-bit wrapped one
                p.in_image = (int'($signed(px)) >= 0) && (int'($signed(py)) >= 0) &&
                             (int'($signed(px)) < int'(cfg_width)) &&
                             (int'($signed(py)) < int'(cfg_height));
                p.done = last_block && (k == 3);
                p.last = (k == 3);
                blk.push_back(p);
            end
        end
    endtask

    function automatic stim_row_t model_row(input logic act, input int sx, input int sy,
                                            input int ex, input int ey);
        stim_row_t r;
        r.act = act;
        r.sx = 16'(sx);
        r.sy = 16'(sy);
        r.ex = 16'(ex);
        r.ey = 16'(ey);
        r.typed = 1'b0;
        r.nres = 0;
        r.bx = 0;
        r.by = 0;
        r.colour = 1'b0;
        r.mask = '0;
        r.done = 1'b0;
        return r;
    endfunction

    function automatic stim_row_t typed_row(input logic act, input int sx, input int sy,
                                            input int ex, input int ey, input int nres,
                                            input int bx, input int by, input logic colour,
                                            input logic [3:0] mask, input bit done);
        stim_row_t r;
        r = model_row(act, sx, sy, ex, ey);
        r.typed = 1'b1;
        r.nres = nres;
        r.bx = bx;
        r.by = by;
        r.colour = colour;
        r.mask = mask;
        r.done = done;
        return r;
    endfunction

    function automatic stim_row_t step_row();
        return model_row(ACT_STEP, $urandom, $urandom, $urandom, $urandom);
    endfunction

    function automatic int clamp16(input int v);
        if (v > 32767)
            return 32767;
        if (v < -32768)
            return -32768;
        return v;
    endfunction

    function automatic int idle_length();
        int r;
        r = $urandom_range(0, 99);
        if (r < 80)
            return $urandom_range(1, 3);
        if (r < 97)
            return $urandom_range(4, 12);
        return $urandom_range(20, 40);
    endfunction

    function automatic int pick_gap();
        if (no_gaps || $urandom_range(0, 99) < 55)
            return 0;
        return idle_length();
    endfunction

    // mostly around the image, some anywhere, a few at the range ends
    function automatic int pick_coord(input int dim);
        int r;
        int v;
        r = $urandom_range(0, 99);
        if (r < 65)
            v = int'($urandom_range(0, (dim + 16) * 16)) - 8 * 16;
        else if (r < 85)
            v = $signed(16'($urandom));
        else
        begin
            case ($urandom_range(0, 4))
                0: v = -32768;
                1: v = 32767;
                2: v = 0;
                3: v = -1;
                default: v = -32767;
            endcase
        end
        return clamp16(v);
    endfunction

    function automatic int pick_end(input int start, input int dim);
        int r;
        r = $urandom_range(0, 99);
        if (r < 25)
            return pick_coord(dim);
        if (r < 30)
            return clamp16(start + int'($urandom_range(0, 31)) - 16);
        return clamp16(start + int'($urandom_range(0, 48 * 16)) - 24 * 16);
    endfunction

    task automatic send_word(input stim_row_t r, output int nres);
        pixel_t blk[$];
        pixel_t p;
        int     gap;
        in_valid <= 1'b1;
        action   <= r.act;
        start_x  <= r.sx;
        start_y  <= r.sy;
        end_x    <= r.ex;
        end_y    <= r.ey;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        advance_line(r, blk);
        if (r.typed)
        begin
            blk = {};
            for (int k = 0; k < r.nres; k++)
            begin
                p.x = 13'(r.bx - (k & 1));
                p.y = 13'(r.by - (k >> 1));
                p.colour = r.colour;
                p.in_image = r.mask[k];
                p.done = r.done && (k == 3);
                p.last = (k == 3);
                blk.push_back(p);
            end
        end
        nres = blk.size();
        foreach (blk[k])
            pending_pixels.push_back(blk[k]);
        gap = pick_gap();
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
    endtask

    // stop offering, wait for every pending pixel to be checked, then let the core settle
    task automatic settle_block();
        in_valid <= 1'b0;
        while (pending_pixels.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_reg(input logic [2:0] addr, input logic [12:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= addr;
        pwdata  <= {19'b0, value};
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready)
            @(posedge clk);
        if (addr == REG_IMAGE_WIDTH)
            cfg_width = value;
        else
            cfg_height = value;
        // read back through a second transfer
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready)
            @(posedge clk);
        if (prdata !== {19'b0, value})
        begin
            $error("prdata: expected %0h, got %0h", {19'b0, value}, prdata);
            mismatch_count++;
        end
        psel    <= 1'b0;
        penable <= 1'b0;
        @(posedge clk);
    endtask

    // receiver holds off while the sender keeps pushing steps into a long line
    task automatic pressure_burst();
        stim_row_t r;
        int        n;
        r = model_row(ACT_LOAD, 0, 0, 1600, 640);
        send_word(r, n);
        hold_req <= hold_req + 1;
        no_gaps = 1'b1;
        repeat (40) send_word(step_row(), n);
        no_gaps = 1'b0;
        settle_block();
    endtask

    task automatic random_lines(input int target);
        stim_row_t r;
        int        produced, n, steps, cap, roll, sx, sy;
        produced = 0;
        while (produced < target)
        begin
            if ($urandom_range(0, 99) < 6)
            begin
                send_word(step_row(), n);
                if (n > 0)
                    produced++;
            end
            else
            begin
                sx = pick_coord(cfg_width);
                sy = pick_coord(cfg_height);
                r = model_row(ACT_LOAD, sx, sy, pick_end(sx, cfg_width),
                              pick_end(sy, cfg_height));
                send_word(r, n);
                produced++;
                cap = ($urandom_range(0, 99) < 3) ? 300 : 24;
                steps = (line_steps > cap) ? cap : line_steps;
                roll = $urandom_range(0, 99);
                if (roll < 15)
                    steps = $urandom_range(0, steps);
                else if (roll < 25)
                    steps = steps + $urandom_range(1, 2);
                repeat (steps)
                begin
                    send_word(step_row(), n);
                    if (n > 0)
                        produced++;
                end
            end
            if ($urandom_range(0, 99) < 3)
                settle_block();
        end
    endtask

    task automatic check_field(input string name, input logic [12:0] want,
                               input logic [12:0] got);
        if (want !== got)
        begin
            $error("%s: expected %0h, got %0h", name, want, got);
            mismatch_count++;
        end
    endtask

    always @(posedge clk)
    begin : pixel_check
        pixel_t want;
        if (rst_n && out_valid && !out_stall)
        begin
            if (pending_pixels.size() == 0)
            begin
                $error("pixel word with nothing pending: x=%0d y=%0d", pixel_x, pixel_y);
                mismatch_count++;
            end
            else
            begin
                want = pending_pixels.pop_front();
                check_field("pixel_x", want.x, pixel_x);
                check_field("pixel_y", want.y, pixel_y);
                check_field("colour_sel", 13'(want.colour), 13'(colour_sel));
                check_field("inside_res", 13'(want.in_image), 13'(inside_res));
                check_field("line_done", 13'(want.done), 13'(line_done));
                check_field("block_last", 13'(want.last), 13'(block_last));
            end
        end
    end

    // output side stall pattern; a hold request forces a long stretch
    always @(posedge clk)
    begin
        if (hold_req != hold_seen)
        begin
            hold_seen <= hold_req;
            hold_left <= HOLD_CYCLES;
            out_stall <= 1'b1;
        end
        else if (hold_left > 0)
            hold_left <= hold_left - 1;
        else if (run_left > 0)
            run_left <= run_left - 1;
        else if (rx_quiet || $urandom_range(0, 99) < 65)
        begin
            out_stall <= 1'b0;
            run_left  <= $urandom_range(0, 12);
        end
        else
        begin
            out_stall <= 1'b1;
            run_left  <= idle_length() - 1;
        end
    end

    always @(posedge clk)
    begin
        if ((in_valid && !in_stall) || (out_valid && !out_stall))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= WATCHDOG_LIMIT)
        begin
            $display("DONE: errors detected");
            $finish;
        end
    end

    initial
    begin : stimulus
        int n;
        int widths[NUM_PHASES];
        int heights[NUM_PHASES];
        widths  = '{1, 4096, 0, 640, 0, 2048, 640};
        heights = '{1, 4096, 480, 0, 0, 2048, 480};
        widths[4]  = $urandom_range(1, 4096);
        heights[4] = $urandom_range(1, 4096);

        // step with no line loaded
        directed_rows.push_back(typed_row(ACT_STEP, 0, 0, 0, 0, 0, 0, 0, 1'b0, 4'b0000, 0));
        // zero length: start block only, done on its last pixel
        directed_rows.push_back(typed_row(ACT_LOAD, 0, 0, 0, 0, 4, 0, 0, 1'b0, 4'b0001, 1));
        directed_rows.push_back(typed_row(ACT_STEP, -1, -1, -1, -1, 0, 0, 0, 1'b0, 4'b0000, 0));
        // three-step horizontal line, unit increment
        directed_rows.push_back(typed_row(ACT_LOAD, 16, 16, 64, 16, 4, 1, 1, 1'b0, 4'b1111, 0));
        directed_rows.push_back(typed_row(ACT_STEP, 0, 0, 0, 0, 4, 2, 1, 1'b1, 4'b1111, 0));
        directed_rows.push_back(typed_row(ACT_STEP, 0, 0, 0, 0, 4, 3, 1, 1'b1, 4'b1111, 0));
        directed_rows.push_back(typed_row(ACT_STEP, 0, 0, 0, 0, 4, 4, 1, 1'b1, 4'b1111, 1));
        directed_rows.push_back(typed_row(ACT_STEP, 0, 0, 0, 0, 0, 0, 0, 1'b0, 4'b0000, 0));
        // full-range diagonal, then abandoned by a load during the line
        directed_rows.push_back(typed_row(ACT_LOAD, -32768, -32768, 32767, 32767,
                                          4, -2048, -2048, 1'b0, 4'b0000, 0));
        directed_rows.push_back(model_row(ACT_STEP, 32767, 32767, -32768, -32768));
        directed_rows.push_back(model_row(ACT_STEP, -32768, 32767, 32767, -32768));
        directed_rows.push_back(typed_row(ACT_LOAD, 32767, -32768, -32768, 32767,
                                          4, 2048, -2048, 1'b0, 4'b0000, 0));
        directed_rows.push_back(model_row(ACT_STEP, 0, 0, 0, 0));
        // rounding at and near the half pixel, and a sub-pixel line
        directed_rows.push_back(model_row(ACT_LOAD, 8, -8, 8, -8));
        directed_rows.push_back(model_row(ACT_LOAD, 7, -9, 7, -9));
        directed_rows.push_back(model_row(ACT_LOAD, 8, 8, 23, 8));
        // image corner: inside on the load, mostly outside one step later
        directed_rows.push_back(typed_row(ACT_LOAD, 10224, 7664, 10240, 7680,
                                          4, 639, 479, 1'b0, 4'b1111, 0));
        directed_rows.push_back(typed_row(ACT_STEP, 0, 0, 0, 0, 4, 640, 480, 1'b1, 4'b1000, 1));
        // steep line going up and left
        directed_rows.push_back(model_row(ACT_LOAD, 1600, 3200, 1440, 320));
        directed_rows.push_back(model_row(ACT_STEP, 0, 0, 0, 0));
        directed_rows.push_back(model_row(ACT_STEP, 0, 0, 0, 0));
        directed_rows.push_back(model_row(ACT_STEP, 0, 0, 0, 0));
        directed_rows.push_back(model_row(ACT_LOAD, 23130, -23131, -23131, 23130));
        directed_rows.push_back(model_row(ACT_STEP, -23131, 23130, 23130, -23131));

        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (directed_rows[i])
            send_word(directed_rows[i], n);

        for (int p = 0; p < NUM_PHASES; p++)
        begin
            settle_block();
            write_reg(REG_IMAGE_WIDTH, 13'(widths[p]));
            write_reg(REG_IMAGE_HEIGHT, 13'(heights[p]));
            no_gaps = (p == 5);
            rx_quiet <= (p == 5);
            if (p == 1)
                pressure_burst();
            random_lines(PHASE_WORDS);
        end

        settle_block();
        if (mismatch_count == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

endmodule
